// ===== hdl/skf_pkg.sv =====
package skf_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned GAIN_W      = 17;
  localparam int unsigned GAIN_FRAC   = 16;
  localparam int unsigned FRAC_BITS_D = 16;

  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  // m_axis tdata: filtered_value then gain, padded to whole bytes
  localparam int unsigned OUT_BITS    = DATA_W + GAIN_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

  // register indexes of the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INITIAL_ESTIMATE  = 2'd2;

  // input op codes
  localparam logic OP_UPDATE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct packed {
    logic load_in;   // capture measurement
    logic restart;   // reload estimate and covariance
    logic predict;   // p1, divisor and error
    logic div_step;  // one restoring division step
    logic mul_err;   // error times gain
    logic mul_cov;   // covariance times one minus gain
    logic update;    // write back estimate and covariance
    logic out_load;  // load the output register
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

endpackage

// ===== hdl/skf_ctrl.sv =====
module skf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_op_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  skf_pkg::status_t stat_i,
  output skf_pkg::cmd_t    cmd_o
);
  import skf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRED = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MULE = 3'd3;
  localparam logic [2:0] ST_MULP = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_op_i == OP_RESTART) begin
            cmd_o.restart = 1'b1;
            state_d       = ST_DONE;
          end else begin
            cmd_o.load_in = 1'b1;
            state_d       = ST_PRED;
          end
        end
      end
      ST_PRED: begin
        cmd_o.predict = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_MULE;
        end
      end
      ST_MULE: begin
        cmd_o.mul_err = 1'b1;
        state_d       = ST_MULP;
      end
      ST_MULP: begin
        cmd_o.mul_cov = 1'b1;
        state_d       = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to be free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/skf_datapath.sv =====
module skf_datapath #(
  parameter int unsigned FRAC_BITS = skf_pkg::FRAC_BITS_D
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [skf_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [skf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [skf_pkg::DATA_W-1:0]      meas_i,
  input  skf_pkg::cmd_t                   cmd_i,
  output skf_pkg::status_t                stat_o,
  output logic [skf_pkg::DATA_W-1:0]      filtered_value_o,
  output logic [skf_pkg::GAIN_W-1:0]      gain_o
);
  import skf_pkg::*;

  localparam logic [DATA_W-1:0] COV_ONE = DATA_W'(1) << FRAC_BITS;
  localparam int unsigned       CNT_W   = $clog2(GAIN_W);
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(GAIN_W - 1);

  // configuration registers
  logic [DATA_W-1:0] q_noise_q, r_noise_q, init_est_q;

  // filter state
  logic signed [DATA_W-1:0] est_q;
  logic [DATA_W-1:0]        cov_q;

  // working registers
  logic signed [DATA_W-1:0] meas_q;
  logic [DATA_W-1:0]        p1_q;
  logic [DATA_W:0]          den_q;
  logic signed [DATA_W:0]   err_q;
  logic [DATA_W+1:0]        rem_q;
  logic [GAIN_W-1:0]        quo_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [GAIN_W-1:0]        gain_q;
  logic signed [51:0]       prod_q;
  logic signed [33:0]       corr_q;
  logic [DATA_W-1:0]        out_est_q;
  logic [GAIN_W-1:0]        out_gain_q;

  logic [DATA_W:0]          p1_sum;
  logic [DATA_W-1:0]        p1_sat;
  logic [DATA_W+1:0]        rem_in;
  logic                     rem_ge;
  logic [GAIN_W-1:0]        gain_w;
  logic signed [33:0]       mul_a;
  logic signed [17:0]       mul_b;
  logic signed [51:0]       prod;
  logic signed [34:0]       est_sum;
  logic signed [DATA_W-1:0] est_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q  <= DATA_W'(655);
      r_noise_q  <= DATA_W'(65536);
      init_est_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_PROCESS_NOISE:     q_noise_q  <= cfg_wdata_i;
        REG_MEASUREMENT_NOISE: r_noise_q  <= cfg_wdata_i;
        REG_INITIAL_ESTIMATE:  init_est_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // predicted covariance, saturating
  assign p1_sum = {1'b0, cov_q} + {1'b0, q_noise_q};
  assign p1_sat = p1_sum[DATA_W] ? '1 : p1_sum[DATA_W-1:0];

  // restoring divider: first step compares p1 itself, then one shifted bit per step
  assign rem_in = (cnt_q == '0) ? {2'b00, p1_q} : {rem_q[DATA_W:0], 1'b0};
  assign rem_ge = rem_in >= {1'b0, den_q};

  assign stat_o.div_last = (cnt_q == CNT_LAST);

  // zero divisor means gain of one
  assign gain_w = (den_q == '0) ? GAIN_ONE : quo_q;

  // shared multiplier
  assign mul_a = cmd_i.mul_err ? {err_q[DATA_W], err_q} : {2'b00, p1_q};
  assign mul_b = cmd_i.mul_err ? {1'b0, gain_w} : {1'b0, GAIN_ONE - gain_q};
  assign prod  = mul_a * mul_b;

  assign est_sum = {{3{est_q[DATA_W-1]}}, est_q} + {corr_q[33], corr_q};
  always_comb begin
    if (est_sum[34:31] == 4'b0000 || est_sum[34:31] == 4'b1111) begin
      est_sat = est_sum[DATA_W-1:0];
    end else if (est_sum[34]) begin
      est_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      est_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= '0;
      cov_q <= COV_ONE;
    end else if (cmd_i.restart) begin
      est_q <= init_est_q;
      cov_q <= COV_ONE;
    end else if (cmd_i.update) begin
      est_q <= est_sat;
      cov_q <= prod_q[47:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      meas_q <= meas_i;
    end
    if (cmd_i.restart) begin
      gain_q <= '0;
    end
    if (cmd_i.predict) begin
      p1_q  <= p1_sat;
      den_q <= {1'b0, p1_sat} + {1'b0, r_noise_q};
      err_q <= {meas_q[DATA_W-1], meas_q} - {est_q[DATA_W-1], est_q};
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? (rem_in - {1'b0, den_q}) : rem_in;
      quo_q <= {quo_q[GAIN_W-2:0], rem_ge};
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.mul_err) begin
      prod_q <= prod;
      gain_q <= gain_w;
    end
    if (cmd_i.mul_cov) begin
      // floor division by 2^16 of the signed correction
      corr_q <= prod_q[49:16];
      prod_q <= prod;
    end
    if (cmd_i.out_load) begin
      out_est_q  <= est_q;
      out_gain_q <= gain_q;
    end
  end

  assign filtered_value_o = out_est_q;
  assign gain_o           = out_gain_q;

endmodule

// ===== hdl/scalar_kalman_filter.sv =====
// One-dimensional Kalman filter in fixed point (estimate Q16.16 signed, covariances
// unsigned with FRAC_BITS fraction bits, gain unsigned Q1.16). Items arrive on the
// s_axis side (tuser = op: 0 update, 1 restart; tdata = measurement) and each gives one
// beat on the m_axis side with the new estimate and the gain used. One item is worked
// at a time: an update runs predict, the divider, both multiplies and the write-back,
// a restart goes straight to the result, and a new item is taken the cycle after the
// result is loaded into the output register. The update time is set by the 17-step
// restoring divider that forms the gain, one quotient bit per cycle, plus the shared
// multiplier used twice. Registers on the cfg port: 0 process noise, 1 measurement
// noise, 2 restart estimate; write them only while the block is idle.
module scalar_kalman_filter #(
  parameter int unsigned FRAC_BITS = skf_pkg::FRAC_BITS_D
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [skf_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [skf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [skf_pkg::DATA_W-1:0]       s_axis_tdata,  // measurement
  input  logic                             s_axis_tuser,  // op
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [skf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // filtered_value, gain, zero pad
);
  import skf_pkg::*;

  cmd_t                  cmd;
  status_t               stat;
  logic [DATA_W-1:0]     filtered_value;
  logic [GAIN_W-1:0]     gain;

  skf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  skf_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .meas_i           (s_axis_tdata),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .filtered_value_o (filtered_value),
    .gain_o           (gain)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, gain, filtered_value};

endmodule

// ===== hdl/skf_checker.sv =====
module skf_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [skf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import skf_pkg::*;

  // one item at a time: input side closes right after a beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // gain never exceeds one
  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[DATA_W +: GAIN_W] <= GAIN_ONE))
    else $error("gain above one");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  import skf_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  localparam longint U32_MAX    = 64'sh0000_0000_FFFF_FFFF;
  localparam longint S32_MAX    = 64'sd2147483647;
  localparam longint S32_MIN    = -64'sd2147483648;
  localparam longint GAIN_UNITY = 64'sd65536;
  localparam logic [31:0] COV_ONE = 32'd1 << FRAC_BITS_D;

  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;
  localparam logic [31:0] ALL_ONE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0]       value;
    logic [GAIN_W-1:0] gain;
  } filter_result_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [DATA_W-1:0]      s_axis_tdata  = '0;  // measurement
  logic                   s_axis_tuser  = 1'b0;  // op
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // filtered_value, gain, zero pad

  // filter state and register copies
  logic signed [31:0] est_state;
  logic [31:0]        cov_state;
  logic [31:0]        q_noise;
  logic [31:0]        r_noise;
  logic signed [31:0] restart_est;

  filter_result_t pending_results[$];
  int unsigned    mismatches    = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;

  scalar_kalman_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic filter_result_t advance_filter(input logic op,
                                                    input logic signed [31:0] meas);
    longint p1, den, kk, err, corr, sum, nxt_cov;
    filter_result_t res;
    if (op == OP_RESTART) begin
      est_state = restart_est;
      cov_state = COV_ONE;
      res.value = restart_est;
      res.gain  = '0;
    end else begin
      p1 = longint'({32'h0, cov_state}) + longint'({32'h0, q_noise});
      if (p1 > U32_MAX) begin
        p1 = U32_MAX;
      end
      den = p1 + longint'({32'h0, r_noise});
      if (den == 0) begin
        kk = longint'({47'h0, GAIN_ONE});
      end else begin
        kk = (p1 <<< GAIN_FRAC) / den;
      end
      err = longint'(meas) - longint'(est_state);
      // correction floors toward minus infinity
      if (err >= 0) begin
        corr = (err * kk) >>> GAIN_FRAC;
      end else begin
        corr = -((((-err) * kk) + (GAIN_UNITY - 1)) >>> GAIN_FRAC);
      end
      sum = longint'(est_state) + corr;
      if (sum > S32_MAX) begin
        sum = S32_MAX;
      end else if (sum < S32_MIN) begin
        sum = S32_MIN;
      end
      nxt_cov   = (p1 * (GAIN_UNITY - kk)) >>> GAIN_FRAC;
      est_state = sum[31:0];
      cov_state = nxt_cov[31:0];
      res.value = sum[31:0];
      res.gain  = kk[GAIN_W-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    filter_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 64'(m_axis_tdata), 64'h0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[DATA_W-1:0] !== want.value) begin
          report_mismatch("filtered_value", 64'(m_axis_tdata[DATA_W-1:0]), 64'(want.value));
        end
        if (m_axis_tdata[DATA_W +: GAIN_W] !== want.gain) begin
          report_mismatch("gain", 64'(m_axis_tdata[DATA_W +: GAIN_W]), 64'(want.gain));
        end
        if (m_axis_tdata[OUT_TDATA_W-1:OUT_BITS] !== '0) begin
          report_mismatch("padding", 64'(m_axis_tdata[OUT_TDATA_W-1:OUT_BITS]), 64'h0);
        end
      end
    end
  end

  task automatic send_item(input logic op, input logic [31:0] meas);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= meas;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(advance_filter(op, meas));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    case (addr)
      REG_PROCESS_NOISE:     q_noise     = data;
      REG_MEASUREMENT_NOISE: r_noise     = data;
      REG_INITIAL_ESTIMATE:  restart_est = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_filter(input logic [31:0] q, input logic [31:0] r,
                            input logic [31:0] x0);
    drain_results();
    write_reg(REG_PROCESS_NOISE, q);
    write_reg(REG_MEASUREMENT_NOISE, r);
    write_reg(REG_INITIAL_ESTIMATE, x0);
  endtask

  function automatic logic [31:0] pick_noise();
    case ($urandom_range(5))
      0:       return '0;
      1:       return ALL_ONE;
      2:       return $urandom_range(65535);
      3:       return $urandom_range(1 << 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_level();
    case ($urandom_range(5))
      0:       return POS_MAX;
      1:       return NEG_MAX;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_values();
    send_item(OP_UPDATE, 32'h0001_0000);
    send_item(OP_UPDATE, 32'hFFFF_0000);
    send_item(OP_UPDATE, 32'h0000_0000);
  endtask

  task automatic test_register_writes();
    set_filter(32'h0000_1000, 32'h0002_0000, 32'h0003_8000);
    // unused index must leave every register alone
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    send_item(OP_RESTART, $urandom);
    send_item(OP_UPDATE, 32'hFFFC_0000);
  endtask

  task automatic test_restart();
    set_filter(32'd655, 32'h0001_0000, POS_MAX);
    send_item(OP_RESTART, ALL_ONE);
    drain_results();
    write_reg(REG_INITIAL_ESTIMATE, NEG_MAX);
    send_item(OP_RESTART, '0);
    send_item(OP_UPDATE, 32'h0000_0001);
  endtask

  task automatic test_zero_divisor();
    set_filter('0, '0, 32'h0000_4000);
    send_item(OP_RESTART, $urandom);
    // gain one drives the covariance to zero, then the divisor is zero
    send_item(OP_UPDATE, 32'h1234_5678);
    send_item(OP_UPDATE, 32'hEDCB_A988);
    send_item(OP_UPDATE, 32'h0000_0000);
  endtask

  task automatic test_cov_overflow();
    set_filter(ALL_ONE, ALL_ONE, '0);
    send_item(OP_RESTART, $urandom);
    send_item(OP_UPDATE, POS_MAX);
    send_item(OP_UPDATE, NEG_MAX);
    set_filter(ALL_ONE, '0, '0);
    send_item(OP_UPDATE, 32'h0001_0000);
  endtask

  task automatic test_estimate_extremes();
    set_filter('0, '0, POS_MAX);
    send_item(OP_RESTART, $urandom);
    send_item(OP_UPDATE, NEG_MAX);
    send_item(OP_UPDATE, POS_MAX);
    set_filter('0, ALL_ONE, NEG_MAX);
    send_item(OP_RESTART, $urandom);
    send_item(OP_UPDATE, POS_MAX);
    send_item(OP_UPDATE, NEG_MAX);
  endtask

  task automatic run_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                  input int unsigned n_items);
    int unsigned done;
    int unsigned pick;
    logic [31:0] truth;
    logic signed [31:0] jitter;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    done = 0;
    while (done < n_items) begin
      set_filter(pick_noise(), pick_noise(), pick_level());
      truth = pick_level();
      send_item(OP_RESTART, $urandom);
      done++;
      repeat ($urandom_range(80, 20)) begin
        pick = $urandom_range(99);
        if (pick < 5) begin
          send_item(OP_RESTART, $urandom);
        end else if (pick < 10) begin
          send_item(OP_UPDATE, $urandom);
        end else if (pick < 13) begin
          send_item(OP_UPDATE, pick_level());
        end else begin
          // noisy readings around a slowly moving level
          if ($urandom_range(19) == 0) begin
            truth = pick_level();
          end
          jitter = $urandom;
          jitter = jitter >>> $urandom_range(31, 8);
          send_item(OP_UPDATE, truth + jitter);
        end
        done++;
      end
    end
  endtask

  initial begin
    q_noise     = 32'd655;
    r_noise     = 32'h0001_0000;
    restart_est = '0;
    est_state   = '0;
    cov_state   = COV_ONE;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_register_writes();
    test_restart();
    test_zero_divisor();
    test_cov_overflow();
    test_estimate_extremes();
    run_random_phase(7, 49, 360);
    run_random_phase(49, 7, 360);
    run_random_phase(0, 0, 360);

    drain_results();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/skf_pkg.sv
hdl/skf_ctrl.sv
hdl/skf_datapath.sv
hdl/scalar_kalman_filter.sv
hdl/skf_checker.sv
dv/testbench.sv
